### src/cfsc_pkg.sv
// Shared constants, types and helpers for the coil fire sequencer / chronograph.
// Self-contained; used by every module under src.
package cfsc_pkg;

    localparam int INTERVAL_BITS = 24;
    localparam int FRAC_BITS     = 8;
    localparam int DIST_W        = 10;
    localparam int ON_TIME_W     = 16;
    localparam int SPEED_W       = 18;
    localparam int GATE_OUT_W    = 24;
    localparam int PHASE_W       = 3;

    localparam int NUM_W  = DIST_W + FRAC_BITS;
    localparam int QCNT_W = $clog2(NUM_W + 1);
    localparam int SAT_W  = (NUM_W > SPEED_W) ? NUM_W : SPEED_W;
    localparam int GCMP_W = (INTERVAL_BITS > GATE_OUT_W) ? INTERVAL_BITS : GATE_OUT_W;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_USED_W  = 1 + PHASE_W + SPEED_W + GATE_OUT_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FIRING = 3'd2;
    localparam logic [PHASE_W-1:0] PH_COAST  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TIMING = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FINISH = 3'd5;

    localparam logic REG_ON_TIME = 1'b0;
    localparam logic REG_DIST    = 1'b1;

    localparam logic [ON_TIME_W-1:0]  ON_TIME_RST = 16'd200;
    localparam logic [DIST_W-1:0]     DIST_RST    = 10'd22;
    localparam logic [SPEED_W-1:0]    SPEED_MAX   = '1;
    localparam logic [GATE_OUT_W-1:0] GATE_MAX    = '1;

    typedef struct packed {
        logic [ON_TIME_W-1:0] on_time;
        logic [DIST_W-1:0]    distance;
    } cfg_t;

    typedef struct packed {
        logic                     start;
        logic [NUM_W-1:0]         num;
        logic [INTERVAL_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [SPEED_W-1:0] sat_speed(input logic [NUM_W-1:0] q);
        logic [SAT_W-1:0] qw;
        qw = SAT_W'(q);
        if (qw > SAT_W'(SPEED_MAX)) begin
            return SPEED_MAX;
        end
        return SPEED_W'(qw);
    endfunction

    function automatic logic [GATE_OUT_W-1:0] sat_gate(input logic [INTERVAL_BITS-1:0] v);
        logic [GCMP_W-1:0] vw;
        vw = GCMP_W'(v);
        if (vw > GCMP_W'(GATE_MAX)) begin
            return GATE_MAX;
        end
        return GATE_OUT_W'(vw);
    endfunction

endpackage

### src/cfsc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on cfsc_pkg (widths, div_req_t / div_rsp_t).
module cfsc_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfsc_pkg::div_req_t  req,
    output cfsc_pkg::div_rsp_t  rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [cfsc_pkg::QCNT_W-1:0]         cnt_reg, cnt_next;
    logic [cfsc_pkg::INTERVAL_BITS-1:0]  rem_reg, rem_next;
    logic [cfsc_pkg::INTERVAL_BITS-1:0]  den_reg, den_next;
    logic [cfsc_pkg::NUM_W-1:0]          quo_reg, quo_next;

    logic [cfsc_pkg::INTERVAL_BITS:0]    rem_sh;
    logic [cfsc_pkg::INTERVAL_BITS+1:0]  diff;
    logic                                fits;

    // Trial subtract; top bit of diff is the borrow.
    assign rem_sh = {rem_reg, quo_reg[cfsc_pkg::NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign fits   = !diff[cfsc_pkg::INTERVAL_BITS+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = cfsc_pkg::QCNT_W'(cfsc_pkg::NUM_W);
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = req.num;
        end else if (busy_reg) begin
            rem_next = fits ? diff[cfsc_pkg::INTERVAL_BITS-1:0]
                            : rem_sh[cfsc_pkg::INTERVAL_BITS-1:0];
            quo_next = {quo_reg[cfsc_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg - cfsc_pkg::QCNT_W'(1);
            if (cnt_reg == cfsc_pkg::QCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

### src/cfsc_regs.sv
// APB register file: coil on-time limit and gate spacing.
// Depends on cfsc_pkg (cfg_t, register indexes, reset values).
module cfsc_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cfsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cfsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cfsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output cfsc_pkg::cfg_t                    cfg
);

    logic [cfsc_pkg::ON_TIME_W-1:0] on_time_reg;
    logic [cfsc_pkg::DIST_W-1:0]    dist_reg;
    logic                           wr_en;
    logic                           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    // word index only; byte-lane bits are ignored
    assign idx    = paddr[cfsc_pkg::APB_ADDR_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_time_reg <= cfsc_pkg::ON_TIME_RST;
            dist_reg    <= cfsc_pkg::DIST_RST;
        end else if (wr_en) begin
            unique case (idx)
                cfsc_pkg::REG_ON_TIME: on_time_reg <= pwdata[cfsc_pkg::ON_TIME_W-1:0];
                cfsc_pkg::REG_DIST:    dist_reg    <= pwdata[cfsc_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            cfsc_pkg::REG_ON_TIME: prdata = cfsc_pkg::APB_DATA_W'(on_time_reg);
            cfsc_pkg::REG_DIST:    prdata = cfsc_pkg::APB_DATA_W'(dist_reg);
            default:               prdata = '0;
        endcase
    end

    assign cfg.on_time  = on_time_reg;
    assign cfg.distance = dist_reg;

endmodule

### src/coil_fire_sequencer_with_chronograph_unit.sv
// Top level: coil fire phase sequencer with light-gate chronograph.
// Depends on cfsc_pkg, cfsc_regs, cfsc_divider.
//
// Usage:
//   s_ channel: one beat per millisecond tick. s_tdata bits, low first:
//     button_pressed, charged, gate1_blocked, gate2_blocked.
//   m_ channel: exactly one result beat per input beat, in order.
//   APB port: reg 0 (addr 0x0) coil on-time limit in ticks, reg 1 (addr 0x4)
//     gate spacing in mm. Write only while no tick is in flight.
// Tick flow:
//   A plain tick is accepted, its state update lands at that edge, and the
//   result beat is presented the next cycle. s_tready then stays low until
//   the result beat is taken. The tick that reaches gate two also runs the
//   restoring divider, one quotient bit per cycle; on its done strobe the
//   saturated speed is loaded and the result beat is presented.
//   The divider is the only multi-cycle unit.
// Stall: a result beat holds, stable, until m_tready; no new tick is taken
//   meanwhile. Reset puts the phase in idle, coil off, counters and the held
//   speed at zero, and the registers at 200 ticks / 22 mm.
module coil_fire_sequencer_with_chronograph_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave stream: [0] button_pressed [1] charged [2] gate1_blocked [3] gate2_blocked
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfsc_pkg::S_TDATA_W-1:0]    s_tdata,
    // master stream: [0] coil_on [3:1] phase [21:4] speed [45:22] gate_interval
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cfsc_pkg::M_TDATA_W-1:0]    m_tdata,
    // tuser: [0] speed_valid
    output logic [0:0]                        m_tuser,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cfsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cfsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cfsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // sequencer codes
    localparam logic CTL_IDLE = 1'b0;
    localparam logic CTL_DIV  = 1'b1;

    cfsc_pkg::cfg_t     cfg;
    cfsc_pkg::div_req_t div_req;
    cfsc_pkg::div_rsp_t div_rsp;

    logic                                ctl_reg;
    logic                                out_valid_reg;
    logic                                spd_valid_reg, spd_valid_next;
    logic [cfsc_pkg::PHASE_W-1:0]        phase_reg, phase_next;
    logic                                coil_reg, coil_next;
    logic [cfsc_pkg::ON_TIME_W-1:0]      elapsed_reg, elapsed_next;
    logic [cfsc_pkg::INTERVAL_BITS-1:0]  interval_reg, interval_next;
    logic [cfsc_pkg::SPEED_W-1:0]        speed_reg, speed_next;

    logic btn, chg, g1, g2;
    logic accept;
    logic div_go;

    cfsc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign btn = s_tdata[0];
    assign chg = s_tdata[1];
    assign g1  = s_tdata[2];
    assign g2  = s_tdata[3];

    // one tick in flight at a time; result register must be empty
    assign s_tready = (ctl_reg == CTL_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Phase update for one tick. Speed on the gate-two tick goes to the divider
    // unless the interval is zero, which saturates directly.
    always_comb begin
        phase_next     = phase_reg;
        coil_next      = coil_reg;
        elapsed_next   = elapsed_reg;
        interval_next  = interval_reg;
        speed_next     = speed_reg;
        spd_valid_next = 1'b0;
        div_go         = 1'b0;
        unique case (phase_reg)
            cfsc_pkg::PH_ARMED: begin
                if (!btn) begin
                    if (chg) begin
                        elapsed_next = '0;
                        phase_next   = cfsc_pkg::PH_FIRING;
                    end else begin
                        phase_next = cfsc_pkg::PH_IDLE;
                    end
                end
            end
            cfsc_pkg::PH_FIRING: begin
                coil_next = 1'b1;
                if (!(&elapsed_reg)) begin
                    elapsed_next = elapsed_reg + cfsc_pkg::ON_TIME_W'(1);
                end
                if (g1) begin
                    coil_next     = 1'b0;
                    interval_next = '0;
                    phase_next    = cfsc_pkg::PH_TIMING;
                end else if (elapsed_next > cfg.on_time) begin
                    phase_next = cfsc_pkg::PH_COAST;
                end
            end
            cfsc_pkg::PH_COAST: begin
                coil_next     = 1'b0;
                interval_next = '0;
                if (g1) begin
                    phase_next = cfsc_pkg::PH_TIMING;
                end
            end
            cfsc_pkg::PH_TIMING: begin
                if (!(&interval_reg)) begin
                    interval_next = interval_reg + cfsc_pkg::INTERVAL_BITS'(1);
                end
                if (g2) begin
                    spd_valid_next = 1'b1;
                    phase_next     = cfsc_pkg::PH_FINISH;
                    if (interval_next == '0) begin
                        speed_next = cfsc_pkg::SPEED_MAX;
                    end else begin
                        div_go = 1'b1;
                    end
                end
            end
            cfsc_pkg::PH_FINISH: begin
                if (!g2) begin
                    phase_next = cfsc_pkg::PH_IDLE;
                end
            end
            default: begin
                // idle, and the unused codes fall back to idle
                phase_next = btn ? cfsc_pkg::PH_ARMED : cfsc_pkg::PH_IDLE;
            end
        endcase
    end

    assign div_req.start = accept && div_go;
    assign div_req.num   = cfsc_pkg::NUM_W'(cfg.distance) << cfsc_pkg::FRAC_BITS;
    assign div_req.den   = interval_next;

    cfsc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg       <= CTL_IDLE;
            out_valid_reg <= 1'b0;
            spd_valid_reg <= 1'b0;
            phase_reg     <= cfsc_pkg::PH_IDLE;
            coil_reg      <= 1'b0;
            elapsed_reg   <= '0;
            interval_reg  <= '0;
            speed_reg     <= '0;
        end else begin
            if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (ctl_reg)
                CTL_IDLE: begin
                    if (accept) begin
                        phase_reg     <= phase_next;
                        coil_reg      <= coil_next;
                        elapsed_reg   <= elapsed_next;
                        interval_reg  <= interval_next;
                        speed_reg     <= speed_next;
                        spd_valid_reg <= spd_valid_next;
                        if (div_go) begin
                            ctl_reg <= CTL_DIV;
                        end else begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                CTL_DIV: begin
                    if (div_rsp.done) begin
                        speed_reg     <= cfsc_pkg::sat_speed(div_rsp.quo);
                        out_valid_reg <= 1'b1;
                        ctl_reg       <= CTL_IDLE;
                    end
                end
                default: ctl_reg <= CTL_IDLE;
            endcase
        end
    end

    // result beat is read straight from state; it cannot change while pending
    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = spd_valid_reg;
    assign m_tdata    = cfsc_pkg::M_TDATA_W'({cfsc_pkg::sat_gate(interval_reg),
                                              speed_reg, phase_reg, coil_reg});

    // divider running means no new tick may be taken
    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> !s_tready)
        else $error("tick accepted while divider busy");

    // a fresh speed only comes with the finishing phase
    a_speed_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (phase_reg == cfsc_pkg::PH_FINISH))
        else $error("speed_valid outside finishing phase");

    // coil can only be driven in firing or the first coasting tick
    a_coil_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        coil_reg |-> (phase_reg == cfsc_pkg::PH_FIRING || phase_reg == cfsc_pkg::PH_COAST))
        else $error("coil on in wrong phase");

    // divider completion must produce a result beat
    a_div_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg == CTL_DIV && div_rsp.done) |=> m_tvalid)
        else $error("divider result not presented");

endmodule

### tb/coil_fire_sequencer_with_chronograph_unit_tb.sv
// Testbench for coil_fire_sequencer_with_chronograph_unit: drives tick beats and APB
// writes, predicts every result beat in-line and checks them in order.
// Depends on cfsc_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module coil_fire_sequencer_with_chronograph_unit_tb;

    // tick level bit positions inside s_tdata
    localparam int BTN = 0;
    localparam int CHG = 1;
    localparam int G1  = 2;
    localparam int G2  = 3;

    localparam int QUO_W = cfsc_pkg::INTERVAL_BITS + cfsc_pkg::NUM_W;

    // register byte addresses: index i at 4*i
    localparam logic [cfsc_pkg::APB_ADDR_W-1:0] ADDR_ON_TIME = {cfsc_pkg::REG_ON_TIME, 2'b00};
    localparam logic [cfsc_pkg::APB_ADDR_W-1:0] ADDR_DIST    = {cfsc_pkg::REG_DIST, 2'b00};

    // Slowest legal run is roughly 700 ticks, each with a possible source gap,
    // divider pass and sink stall; the limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 400000;
    // Covers a divider pass, with padding.
    localparam int SETTLE_CYCLES = 30;
    localparam int SHOW_LIMIT    = 10;

    typedef struct packed {
        logic                            coil_on;
        logic [cfsc_pkg::PHASE_W-1:0]    phase;
        logic                            speed_valid;
        logic [cfsc_pkg::SPEED_W-1:0]    speed;
        logic [cfsc_pkg::GATE_OUT_W-1:0] gate_interval;
    } tick_report_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cfsc_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cfsc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [0:0]                      m_tuser;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [cfsc_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [cfsc_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [cfsc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Predicted sequencer state and its register copy
    logic [cfsc_pkg::PHASE_W-1:0]       shot_phase  = cfsc_pkg::PH_IDLE;
    logic                               coil_state  = 1'b0;
    logic [cfsc_pkg::ON_TIME_W-1:0]     fire_ticks  = '0;
    logic [cfsc_pkg::INTERVAL_BITS-1:0] gate_ticks  = '0;
    logic [cfsc_pkg::SPEED_W-1:0]       held_speed  = '0;
    logic [cfsc_pkg::ON_TIME_W-1:0]     on_time_cfg = cfsc_pkg::ON_TIME_RST;
    logic [cfsc_pkg::DIST_W-1:0]        dist_cfg    = cfsc_pkg::DIST_RST;

    tick_report_t pending_reports[$];

    bit src_pause_on  = 1'b1;
    bit sink_pause_on = 1'b1;

    int fail_count      = 0;
    int beats_sent      = 0;
    int beats_checked   = 0;
    int speed_reports   = 0;
    int settings_loaded = 0;
    int cycle_count     = 0;

    coil_fire_sequencer_with_chronograph_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [0] button [1] charged [2] gate1 [3] gate2, rest zero
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [0] coil_on [3:1] phase [21:4] speed [45:22] gate_interval
        .m_tuser  (m_tuser),   // [0] speed_valid
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("[coil_fire_sequencer_with_chronograph_unit] ERROR");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endfunction

    // distance / interval in Q.FRAC_BITS, truncated; zero interval saturates
    function automatic logic [cfsc_pkg::SPEED_W-1:0] speed_from(
        input logic [cfsc_pkg::DIST_W-1:0]        dist_mm,
        input logic [cfsc_pkg::INTERVAL_BITS-1:0] ticks);
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
        if (ticks == '0) begin
            return cfsc_pkg::SPEED_MAX;
        end
        num = QUO_W'(dist_mm) << cfsc_pkg::FRAC_BITS;
        quo = num / ticks;
        if (quo > QUO_W'(cfsc_pkg::SPEED_MAX)) begin
            return cfsc_pkg::SPEED_MAX;
        end
        return quo[cfsc_pkg::SPEED_W-1:0];
    endfunction

    // One millisecond tick of the sequencer; returns the report it produces.
    function automatic tick_report_t advance_shot_state(input logic [3:0] lv);
        tick_report_t r;
        r.speed_valid = 1'b0;
        case (shot_phase)
            cfsc_pkg::PH_ARMED: begin
                // fires on release, but only with the cap charged
                if (!lv[BTN]) begin
                    if (lv[CHG]) begin
                        fire_ticks = '0;
                        shot_phase = cfsc_pkg::PH_FIRING;
                    end else begin
                        shot_phase = cfsc_pkg::PH_IDLE;
                    end
                end
            end
            cfsc_pkg::PH_FIRING: begin
                coil_state = 1'b1;
                if (fire_ticks != '1) begin
                    fire_ticks = fire_ticks + 1'b1;
                end
                // gate one wins over the on-time limit
                if (lv[G1]) begin
                    coil_state = 1'b0;
                    gate_ticks = '0;
                    shot_phase = cfsc_pkg::PH_TIMING;
                end else if (fire_ticks > on_time_cfg) begin
                    shot_phase = cfsc_pkg::PH_COAST;
                end
            end
            cfsc_pkg::PH_COAST: begin
                coil_state = 1'b0;
                gate_ticks = '0;
                if (lv[G1]) begin
                    shot_phase = cfsc_pkg::PH_TIMING;
                end
            end
            cfsc_pkg::PH_TIMING: begin
                if (gate_ticks != '1) begin
                    gate_ticks = gate_ticks + 1'b1;
                end
                if (lv[G2]) begin
                    held_speed    = speed_from(dist_cfg, gate_ticks);
                    r.speed_valid = 1'b1;
                    shot_phase    = cfsc_pkg::PH_FINISH;
                end
            end
            cfsc_pkg::PH_FINISH: begin
                if (!lv[G2]) begin
                    shot_phase = cfsc_pkg::PH_IDLE;
                end
            end
            default: begin
                // idle, and the unused codes behave like idle
                shot_phase = lv[BTN] ? cfsc_pkg::PH_ARMED : cfsc_pkg::PH_IDLE;
            end
        endcase
        r.coil_on       = coil_state;
        r.phase         = shot_phase;
        r.speed         = held_speed;
        r.gate_interval = cfsc_pkg::GATE_OUT_W'(gate_ticks);
        return r;
    endfunction

    // Random levels biased so most ticks push the current shot forward.
    function automatic logic [3:0] pick_levels(input int fire_odds);
        logic [3:0] v;
        v = 4'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            return v;   // plain noise
        end
        case (shot_phase)
            cfsc_pkg::PH_ARMED: begin
                v[BTN] = ($urandom_range(0, 2) == 0);
                v[CHG] = ($urandom_range(0, 7) != 0);
            end
            cfsc_pkg::PH_FIRING: v[G1] = ($urandom_range(0, fire_odds - 1) == 0);
            cfsc_pkg::PH_COAST:  v[G1] = ($urandom_range(0, 3) == 0);
            cfsc_pkg::PH_TIMING: v[G2] = ($urandom_range(0, 11) == 0);
            cfsc_pkg::PH_FINISH: v[G2] = ($urandom_range(0, 1) == 0);
            default:             v[BTN] = ($urandom_range(0, 2) != 0);
        endcase
        return v;
    endfunction

    // Send one tick beat. tvalid stays high on return so a back-to-back beat
    // needs no second assignment in the same step; lowered only before a gap.
    task automatic send_tick(input logic [3:0] levels);
        int unsigned gap;
        gap = src_pause_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cfsc_pkg::S_TDATA_W-4){1'b0}}, levels};
        do @(posedge aclk); while (!s_tready);
        pending_reports.push_back(advance_shot_state(levels));
        beats_sent++;
    endtask

    // Drop tvalid, wait out every outstanding report and a possible divider pass.
    task automatic drain_ticks();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [cfsc_pkg::APB_ADDR_W-1:0] addr,
                             input logic [cfsc_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Load both registers with the unit idle; upper data bits carry junk.
    task automatic load_settings(input logic [cfsc_pkg::ON_TIME_W-1:0] on_time,
                                 input logic [cfsc_pkg::DIST_W-1:0] dist_mm);
        drain_ticks();
        apb_write(ADDR_ON_TIME, {16'($urandom), on_time});
        on_time_cfg = on_time;
        apb_write(ADDR_DIST, {22'($urandom), dist_mm});
        dist_cfg = dist_mm;
        settings_loaded++;
    endtask

    // Well-formed shot from idle: press, charged release, pre_g1 ticks with
    // gate one clear, gate one, pre_g2 ticks with gate two clear, gate two,
    // gate two clear again. Unused levels are random.
    task automatic run_shot(input int pre_g1, input int pre_g2);
        logic [3:0] v;
        v = 4'($urandom); v[BTN] = 1'b1;                 send_tick(v);
        v = 4'($urandom); v[BTN] = 1'b0; v[CHG] = 1'b1;  send_tick(v);
        repeat (pre_g1) begin
            v = 4'($urandom); v[G1] = 1'b0;              send_tick(v);
        end
        v = 4'($urandom); v[G1] = 1'b1;                  send_tick(v);
        repeat (pre_g2) begin
            v = 4'($urandom); v[G2] = 1'b0;              send_tick(v);
        end
        v = 4'($urandom); v[G2] = 1'b1;                  send_tick(v);
        v = 4'($urandom); v[G2] = 1'b0;                  send_tick(v);
    endtask

    // Reset defaults: every phase edge but those into and out of coasting, an uncharged release, both gate paths.
    task automatic test_directed_shots();
        send_tick(4'b0000);   // idle holds
        send_tick(4'b1111);   // all levels high: button arms
        send_tick(4'b0001);   // held button stays armed
        send_tick(4'b0000);   // release without charge drops to idle
        send_tick(4'b0001);
        send_tick(4'b0010);   // charged release starts firing
        send_tick(4'b1011);   // firing, gate one clear, coil on
        send_tick(4'b0100);   // gate one: coil off, timing
        send_tick(4'b0000);
        send_tick(4'b0000);
        send_tick(4'b1000);   // gate two after three ticks
        send_tick(4'b1000);   // finishing holds while gate two blocked
        send_tick(4'b0000);   // back to idle
        send_tick(4'b0001);
        send_tick(4'b0010);
        send_tick(4'b0100);   // gate one on the first firing tick
        send_tick(4'b1000);   // shortest interval of one tick
        send_tick(4'b0000);
    endtask

    // On-time limit runs out before gate one, so the shot coasts.
    task automatic test_on_time_expiry();
        load_settings('0, 10'h3FF);   // ends on the first firing tick
        run_shot(3, 4);
        load_settings(16'd5, 10'd1);
        run_shot(8, 2);
    endtask

    task automatic test_zero_distance();
        load_settings(16'd10, '0);
        run_shot(2, 5);
    endtask

    // Top on-time value: firing never expires on its own.
    task automatic test_max_on_time();
        load_settings('1, 10'h3FF);
        run_shot(300, 3);
    endtask

    task automatic test_random_shots();
        logic [cfsc_pkg::ON_TIME_W-1:0] on_time;
        logic [cfsc_pkg::DIST_W-1:0]    dist_mm;
        int                             odds;
        for (int s = 0; s < 6; s++) begin
            odds = 20;
            case (s)
                0: begin on_time = '0;    dist_mm = 10'h3FF; end
                1: begin on_time = 16'd1; dist_mm = 10'd1;   end
                2: begin
                    on_time = 16'($urandom_range(41, 65535));
                    dist_mm = 10'($urandom_range(1, 1023));
                    odds    = 8;   // long limit: gate one ends firing
                end
                default: begin
                    on_time = 16'($urandom_range(0, 40));
                    dist_mm = 10'($urandom_range(1, 1023));
                end
            endcase
            load_settings(on_time, dist_mm);
            // s == 1 runs with no idling on either side
            src_pause_on  = (s != 1) && (s != 4);
            sink_pause_on = (s != 1) && (s != 5);
            repeat (50) send_tick(pick_levels(odds));
        end
        src_pause_on  = 1'b1;
        sink_pause_on = 1'b1;
    endtask

    // Result sink: draws a stall per beat, keeps tready high across
    // back-to-back beats with a single assignment per step.
    initial begin : result_sink
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = sink_pause_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Checker: each accepted result beat against the oldest prediction.
    always @(posedge aclk) begin
        tick_report_t got;
        tick_report_t want;
        string        bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.coil_on       = m_tdata[0];
            got.phase         = m_tdata[3:1];
            got.speed         = m_tdata[21:4];
            got.gate_interval = m_tdata[45:22];
            got.speed_valid   = m_tuser[0];
            if (pending_reports.size() == 0) begin
                note_failure($sformatf("unexpected result beat coil=%0d phase=%0d",
                                       got.coil_on, got.phase));
            end else begin
                want = pending_reports.pop_front();
                beats_checked++;
                if (want.speed_valid) begin
                    speed_reports++;
                end
                bad = "";
                if (got.coil_on !== want.coil_on)             bad = {bad, " coil_on"};
                if (got.phase !== want.phase)                 bad = {bad, " phase"};
                if (got.speed_valid !== want.speed_valid)     bad = {bad, " speed_valid"};
                if (got.speed !== want.speed)                 bad = {bad, " speed"};
                if (got.gate_interval !== want.gate_interval) bad = {bad, " gate_interval"};
                if (bad != "") begin
                    note_failure($sformatf(
                        "beat %0d bad:%s exp coil=%0d ph=%0d sv=%0d spd=%0d gi=%0d"
                        , beats_checked, bad, want.coil_on, want.phase,
                        want.speed_valid, want.speed, want.gate_interval));
                    if (fail_count <= SHOW_LIMIT) begin
                        $display("    got coil=%0d ph=%0d sv=%0d spd=%0d gi=%0d",
                                 got.coil_on, got.phase, got.speed_valid,
                                 got.speed, got.gate_interval);
                    end
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_shots();
        test_on_time_expiry();
        test_zero_distance();
        test_max_on_time();
        test_random_shots();

        drain_ticks();
        if (pending_reports.size() != 0) begin
            note_failure($sformatf("%0d reports never arrived", pending_reports.size()));
        end

        $display("ran %0d tick beats, checked %0d result beats, %0d speed reports",
                 beats_sent, beats_checked, speed_reports);
        $display("over %0d register settings plus reset defaults; %0d failures",
                 settings_loaded, fail_count);
        if (fail_count == 0) begin
            $display("[coil_fire_sequencer_with_chronograph_unit] OK");
        end else begin
            $display("[coil_fire_sequencer_with_chronograph_unit] ERROR");
        end
        $finish;
    end

endmodule
